[hdl/nfaem_pkg.sv]
`timescale 1ns / 1ps

package nfaem_pkg;

    localparam int IDX_FIELD_W = 4;
    localparam int SET_FIELD_W = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'd1;

    typedef enum logic [1:0] {
        KIND_ADD_SYM = 2'd0,
        KIND_ADD_EPS = 2'd1,
        KIND_START   = 2'd2,
        KIND_SYMBOL  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_MERGE  = 2'd1,
        ST_GATHER = 2'd2,
        ST_CLOSE  = 2'd3
    } seq_state_t;

    typedef struct packed {
        kind_t                  kind;
        logic [IDX_FIELD_W-1:0] from_index;
        logic [IDX_FIELD_W-1:0] to_index;
        logic [IDX_FIELD_W-1:0] symbol;
    } item_t;

    typedef struct packed {
        logic                   accepted;
        logic                   dead;
        logic [SET_FIELD_W-1:0] active_set;
    } result_t;

endpackage

[hdl/nfa_epsilon_matcher.sv]
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// item      item_valid / item_ready    item   (kind, from_index, to_index, symbol)
// result    result_valid / result_ready result (accepted, dead, active_set)
// cfg       cfg_valid / cfg_ready      cfg_index, cfg_data (cfg_ready is always high)
//
// Add epsilon sets its mask bit directly. Add symbol transition does a read-modify-write
// of the transition RAM. Start runs the epsilon closure; symbol first scans the RAM row
// of each of the min(NUM_STATES, 16) states and, unless no state moves, then runs the
// closure in rounds of the shared epsilon OR unit until the set stops growing.
// Reset clears tables (valid bit per RAM entry), active set, dead flag and config registers.
// item_ready is low while a transaction is in flight or an unaccepted result holds
// the output register; a stalled result never blocks the config channel.
module nfa_epsilon_matcher #(
    parameter int NUM_STATES  = 16,
    parameter int NUM_SYMBOLS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  nfaem_pkg::item_t                    item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output nfaem_pkg::result_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nfaem_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nfaem_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import nfaem_pkg::*;

    // Indexes are 4 bits wide, so nothing beyond 16 states or symbols is reachable.
    localparam int STATES_EFF = (NUM_STATES < 16) ? NUM_STATES : 16;
    localparam int SYMS_EFF   = (NUM_SYMBOLS < 16) ? NUM_SYMBOLS : 16;
    localparam int DEPTH      = STATES_EFF * SYMS_EFF;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int IDX_W      = $clog2(STATES_EFF);
    localparam int CNT_W      = $clog2(STATES_EFF + 1);

    seq_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [ADDR_W-1:0]        addr_reg, addr_next;
    logic [STATES_EFF-1:0]    acc_reg, acc_next;
    logic [STATES_EFF-1:0]    set_reg, set_next;
    logic [STATES_EFF-1:0]    act_reg, act_next;
    logic                     dead_reg, dead_next;
    logic                     res_valid_reg, res_valid_next;
    result_t                  res_reg, res_next;
    logic [IDX_FIELD_W-1:0]   start_reg;
    logic [SET_FIELD_W-1:0]   amask_reg;
    logic [STATES_EFF-1:0]    eps_reg [STATES_EFF];

    logic [STATES_EFF-1:0]    sym_mem [DEPTH];
    logic [DEPTH-1:0]         sym_vld_reg;
    logic [STATES_EFF-1:0]    rd_data_reg;
    logic                     rd_vld_reg;
    logic                     take_reg;

    logic                     item_fire;
    logic                     from_ok, to_ok, sym_ok, start_ok;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    logic [STATES_EFF-1:0]    to_bit, start_bit;
    logic [STATES_EFF-1:0]    rd_masked, piece, gathered, grown;
    logic                     rd_en, sym_we, eps_we, load_res;

    assign item_fire = item_valid && item_ready;
    assign item_ready = (state_reg == ST_IDLE) && (!res_valid_reg || result_ready);
    assign cfg_ready = 1'b1;
    assign result_valid = res_valid_reg;
    assign result = res_reg;

    assign from_ok  = {1'b0, item.from_index} < 5'(STATES_EFF);
    assign to_ok    = {1'b0, item.to_index}   < 5'(STATES_EFF);
    assign sym_ok   = {1'b0, item.symbol}     < 5'(SYMS_EFF);
    assign start_ok = {1'b0, start_reg}       < 5'(STATES_EFF);

    assign wr_addr   = ADDR_W'(int'(item.from_index) * SYMS_EFF + int'(item.symbol));
    assign rd_addr   = (state_reg == ST_IDLE) ? wr_addr : addr_reg;
    assign to_bit    = STATES_EFF'(1) << item.to_index[IDX_W-1:0];
    assign start_bit = STATES_EFF'(1) << start_reg[IDX_W-1:0];

    // Entries never written read as no transitions
    assign rd_masked = rd_vld_reg ? rd_data_reg : '0;
    assign piece     = (cnt_reg != '0 && take_reg) ? rd_masked : '0;
    assign gathered  = acc_reg | piece;

    // Shared epsilon unit: one round of OR-ing the masks of all states in the set
    always_comb
    begin
        grown = set_reg;
        for (int s = 0; s < STATES_EFF; s++)
        begin
            if (set_reg[s])
            begin
                grown = grown | eps_reg[s];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        acc_next   = acc_reg;
        set_next   = set_reg;
        act_next   = act_reg;
        dead_next  = dead_reg;
        load_res   = 1'b0;
        rd_en      = 1'b0;
        sym_we     = 1'b0;
        eps_we     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    case (item.kind)
                        KIND_ADD_SYM:
                        begin
                            if (from_ok && to_ok && sym_ok)
                            begin
                                rd_en      = 1'b1;
                                addr_next  = wr_addr;
                                set_next   = to_bit;
                                state_next = ST_MERGE;
                            end
                            else
                            begin
                                load_res = 1'b1;
                            end
                        end
                        KIND_ADD_EPS:
                        begin
                            eps_we   = from_ok && to_ok;
                            load_res = 1'b1;
                        end
                        KIND_START:
                        begin
                            dead_next = 1'b0;
                            if (start_ok)
                            begin
                                set_next   = start_bit;
                                state_next = ST_CLOSE;
                            end
                            else
                            begin
                                act_next = '0;
                                load_res = 1'b1;
                            end
                        end
                        KIND_SYMBOL:
                        begin
                            if (sym_ok)
                            begin
                                cnt_next   = '0;
                                addr_next  = ADDR_W'(item.symbol);
                                acc_next   = '0;
                                state_next = ST_GATHER;
                            end
                            else
                            begin
                                dead_next = 1'b1;
                                act_next  = '0;
                                load_res  = 1'b1;
                            end
                        end
                        default:
                        begin
                            load_res = 1'b1;
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                sym_we     = 1'b1;
                load_res   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_GATHER:
            begin
                // Read for state cnt is issued now, its row is merged next cycle
                rd_en    = cnt_reg < CNT_W'(STATES_EFF);
                acc_next = gathered;
                cnt_next = cnt_reg + CNT_W'(1);
                if (rd_en)
                begin
                    addr_next = addr_reg + ADDR_W'(SYMS_EFF);
                end
                else if (gathered == '0)
                begin
                    dead_next  = 1'b1;
                    act_next   = '0;
                    load_res   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    set_next   = gathered;
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                if (grown == set_reg)
                begin
                    act_next   = set_reg;
                    load_res   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    set_next = grown;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_valid_next = load_res || (res_valid_reg && !result_ready);
        res_next = res_reg;
        if (load_res)
        begin
            res_next.dead       = dead_next;
            res_next.accepted   = !dead_next && (|(act_next & amask_reg[STATES_EFF-1:0]));
            res_next.active_set = SET_FIELD_W'(act_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            act_reg       <= '0;
            dead_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            start_reg     <= '0;
            amask_reg     <= '0;
            sym_vld_reg   <= '0;
            for (int s = 0; s < STATES_EFF; s++)
            begin
                eps_reg[s] <= '0;
            end
        end
        else
        begin
            cnt_reg       <= cnt_next;
            act_reg       <= act_next;
            dead_reg      <= dead_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_START_INDEX: start_reg <= cfg_data[IDX_FIELD_W-1:0];
                    CFG_ACCEPT_MASK: amask_reg <= cfg_data[SET_FIELD_W-1:0];
                    default: ;
                endcase
            end
            if (sym_we)
            begin
                sym_vld_reg[addr_reg] <= 1'b1;
            end
            if (eps_we)
            begin
                eps_reg[item.from_index[IDX_W-1:0]][item.to_index[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        acc_reg  <= acc_next;
        set_reg  <= set_next;
        res_reg  <= res_next;
        take_reg <= act_reg[cnt_reg[IDX_W-1:0]];
    end

    // Transition RAM: one port, registered read
    always_ff @(posedge clk)
    begin
        if (sym_we)
        begin
            sym_mem[addr_reg] <= rd_masked | set_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= sym_mem[rd_addr];
            rd_vld_reg  <= sym_vld_reg[rd_addr];
        end
    end

    a_dead_empty: assert property (@(posedge clk) disable iff (!rst_n)
        dead_reg |-> act_reg == '0)
        else $error("dead word with non-empty active set");

    a_busy_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !res_valid_reg)
        else $error("result pending while a transaction is in flight");

    a_close_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLOSE |-> set_reg != '0)
        else $error("closure started on an empty set");

    a_merge_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MERGE |-> $onehot(set_reg))
        else $error("transition merge without a single target");

    a_gather_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GATHER |-> cnt_reg <= CNT_W'(STATES_EFF))
        else $error("scan ran past the last state");

    a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.accepted && res_reg.dead))
        else $error("result both accepted and dead");

endmodule

[test/nfa_epsilon_matcher_test.sv]
`timescale 1ns / 1ps

module nfa_epsilon_matcher_test;
    import nfaem_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nfa_epsilon_matcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow automaton: next-state masks per state and symbol, epsilon masks per state
    logic [15:0] next_on_symbol [16][16];
    logic [15:0] next_on_epsilon [16];
    logic [15:0] live_states;
    logic        word_dead;
    logic [3:0]  start_state;
    logic [15:0] accepting_states;

    result_t pending_results [$];
    int      errors;

    // Sender and receiver pacing
    int burst_left;
    bit gaps_on;
    int stall_pct;
    bit hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [3:0] rand_index();
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic item_t make_item(kind_t k, logic [3:0] src, logic [3:0] dst,
                                        logic [3:0] sym);
        item_t it;
        it.kind       = k;
        it.from_index = src;
        it.to_index   = dst;
        it.symbol     = sym;
        return it;
    endfunction

    // Random set member, or any state when the set is empty
    function automatic logic [3:0] pick_member(logic [15:0] set);
        logic [3:0] idx;
        idx = rand_index();
        if (set != 16'h0)
        begin
            while (!set[idx])
                idx = rand_index();
        end
        return idx;
    endfunction

    function automatic logic [15:0] close_epsilon(logic [15:0] set);
        logic [15:0] grown;
        for (int r = 0; r < 16; r++)
        begin
            grown = set;
            for (int s = 0; s < 16; s++)
                if (set[s])
                    grown = grown | next_on_epsilon[s];
            if (grown == set)
                break;
            set = grown;
        end
        return set;
    endfunction

    function automatic result_t predict_match(item_t it);
        result_t     res;
        logic [15:0] nxt;
        case (it.kind)
            KIND_ADD_SYM:
                next_on_symbol[it.from_index][it.symbol] =
                    next_on_symbol[it.from_index][it.symbol] | (16'h1 << it.to_index);
            KIND_ADD_EPS:
                next_on_epsilon[it.from_index] =
                    next_on_epsilon[it.from_index] | (16'h1 << it.to_index);
            KIND_START:
            begin
                word_dead   = 1'b0;
                live_states = close_epsilon(16'h1 << start_state);
            end
            KIND_SYMBOL:
            begin
                nxt = 16'h0;
                for (int s = 0; s < 16; s++)
                    if (live_states[s])
                        nxt = nxt | next_on_symbol[s][it.symbol];
                if (nxt == 16'h0)
                begin
                    word_dead   = 1'b1;
                    live_states = 16'h0;
                end
                else
                begin
                    live_states = close_epsilon(nxt);
                end
            end
            default: ;
        endcase
        res.accepted   = !word_dead && ((live_states & accepting_states) != 16'h0);
        res.dead       = word_dead;
        res.active_set = live_states;
        return res;
    endfunction

    // Offer one item, hold it until accepted, then maybe open a gap
    task automatic send_item(input item_t it);
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        pending_results.push_back(predict_match(it));
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 24);
            if (gaps_on)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_START_INDEX)
            start_state = data[3:0];
        else
            accepting_states = data;
    endtask

    task automatic set_config(input logic [3:0] start, input logic [15:0] accept);
        cfg_write(CFG_START_INDEX, {12'h0, start});
        cfg_write(CFG_ACCEPT_MASK, accept);
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        errors++;
        $display("%0t: %s expected %h got %h", $time, field, want, got);
    endtask

    // Empty tables right after reset: symbol before any start, then a bare start
    task automatic test_after_reset();
        send_item(make_item(KIND_SYMBOL, 4'd0, 4'd0, 4'd0));
        send_item(make_item(KIND_START, 4'd0, 4'd0, 4'd0));
        wait_drain();
    endtask

    task automatic test_directed_automaton();
        cfg_write(CFG_ACCEPT_MASK, 16'hFFFF);
        send_item(make_item(KIND_START, 4'd15, 4'd15, 4'd15));
        // epsilon cycle 0 -> 1 -> 2 -> 0 and a self loop on the top state
        send_item(make_item(KIND_ADD_EPS, 4'd0, 4'd1, 4'd0));
        send_item(make_item(KIND_ADD_EPS, 4'd1, 4'd2, 4'd15));
        send_item(make_item(KIND_ADD_EPS, 4'd2, 4'd0, 4'd0));
        send_item(make_item(KIND_ADD_EPS, 4'd15, 4'd15, 4'd15));
        send_item(make_item(KIND_START, 4'd0, 4'd0, 4'd0));
        send_item(make_item(KIND_ADD_SYM, 4'd2, 4'd15, 4'd15));
        send_item(make_item(KIND_ADD_SYM, 4'd15, 4'd0, 4'd0));
        send_item(make_item(KIND_SYMBOL, 4'd0, 4'd0, 4'd15));
        send_item(make_item(KIND_SYMBOL, 4'd0, 4'd0, 4'd0));
        // no move on this symbol: word dies, stays dead, add items leave it dead
        send_item(make_item(KIND_SYMBOL, 4'd0, 4'd0, 4'd7));
        send_item(make_item(KIND_SYMBOL, 4'd0, 4'd0, 4'd0));
        send_item(make_item(KIND_ADD_SYM, 4'd5, 4'd9, 4'd3));
        send_item(make_item(KIND_START, 4'd0, 4'd0, 4'd0));
        set_config(4'd15, 16'h8000);
        send_item(make_item(KIND_START, 4'd0, 4'd0, 4'd0));
        send_item(make_item(KIND_SYMBOL, 4'd0, 4'd0, 4'd0));
        set_config(4'd0, 16'h0000);
        wait_drain();
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        gaps_on   = 1'b0;
        stall_pct = 0;
        set_config(4'd0, 16'h0007);
        hold_req = 1'b1;
        for (int k = 0; k < 20; k++)
        begin
            if (k % 4 == 0)
                send_item(make_item(KIND_START, rand_index(), rand_index(), rand_index()));
            else
                send_item(make_item(KIND_SYMBOL, rand_index(), rand_index(),
                                    4'($urandom_range(0, 3))));
        end
        wait_drain();
    endtask

    task automatic test_random_words();
        int          sent;
        int          pick;
        int          len;
        int          sym_hi;
        logic [3:0]  sym;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    set_config(4'd0, 16'hFFFF);
                    gaps_on   = 1'b1;
                    stall_pct = 30;
                end
                1:
                begin
                    set_config(4'd15, 16'h0000);
                    gaps_on   = 1'b0;
                    stall_pct = 0;
                end
                2:
                begin
                    set_config(rand_index(), 16'($urandom()));
                    gaps_on   = 1'b1;
                    stall_pct = 70;
                end
                default:
                begin
                    set_config(rand_index(), 16'($urandom()));
                    gaps_on   = 1'($urandom_range(0, 1));
                    stall_pct = $urandom_range(0, 60);
                end
            endcase
            sym_hi = (p < 4) ? 3 : 7;
            sent   = 0;
            while (sent < 135)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    send_item(make_item(KIND_ADD_EPS, rand_index(), rand_index(),
                                        rand_index()));
                    sent++;
                end
                else if (pick < 88)
                begin
                    // a word: start, then symbols, growing moves out of live states
                    send_item(make_item(KIND_START, rand_index(), rand_index(),
                                        rand_index()));
                    sent++;
                    len = $urandom_range(1, 8);
                    for (int k = 0; k < len; k++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            sym = rand_index();
                        else
                            sym = 4'($urandom_range(0, sym_hi));
                        if ($urandom_range(0, 99) < 30)
                        begin
                            send_item(make_item(KIND_ADD_SYM, pick_member(live_states),
                                                rand_index(), sym));
                            sent++;
                        end
                        send_item(make_item(KIND_SYMBOL, rand_index(), rand_index(), sym));
                        sent++;
                    end
                end
                else
                begin
                    send_item(make_item(kind_t'($urandom_range(0, 3)), rand_index(),
                                        rand_index(), rand_index()));
                    sent++;
                end
            end
        end
        wait_drain();
    endtask

    // Chain 0 -> 1 -> ... -> 15 forces the closure through every round
    task automatic test_long_epsilon_chain();
        gaps_on   = 1'b1;
        stall_pct = 20;
        for (int i = 0; i < 15; i++)
            send_item(make_item(KIND_ADD_EPS, 4'(i), 4'(i + 1), rand_index()));
        set_config(4'd0, 16'h8000);
        send_item(make_item(KIND_START, rand_index(), rand_index(), rand_index()));
        for (int k = 0; k < 4; k++)
            send_item(make_item(KIND_SYMBOL, rand_index(), rand_index(), rand_index()));
        set_config(4'd15, 16'h0001);
        send_item(make_item(KIND_START, rand_index(), rand_index(), rand_index()));
        send_item(make_item(KIND_SYMBOL, rand_index(), rand_index(), 4'd0));
        wait_drain();
    endtask

    // Result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, none", 0, int'(result));
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.accepted !== result.accepted)
                    report_mismatch("accepted", int'(want.accepted),
                                    int'(result.accepted));
                if (want.dead !== result.dead)
                    report_mismatch("dead", int'(want.dead), int'(result.dead));
                if (want.active_set !== result.active_set)
                    report_mismatch("active_set", int'(want.active_set),
                                    int'(result.active_set));
            end
        end
    end

    // Receiver stall pattern, with a long hold-off on request
    initial
    begin
        int run_left;
        bit level;
        run_left = 0;
        level    = 1'b1;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    level    = ($urandom_range(0, 99) >= stall_pct);
                    run_left = $urandom_range(1, 6);
                end
                run_left--;
                result_ready <= level;
            end
        end
    end

    // Watchdog: cycles without any transaction on any channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog expired", $time);
        $display("nfa_epsilon_matcher_test NOT OK");
        $finish;
    end

    initial
    begin
        for (int s = 0; s < 16; s++)
        begin
            next_on_epsilon[s] = 16'h0;
            for (int y = 0; y < 16; y++)
                next_on_symbol[s][y] = 16'h0;
        end
        live_states      = 16'h0;
        word_dead        = 1'b0;
        start_state      = 4'd0;
        accepting_states = 16'h0;
        errors           = 0;
        burst_left       = 0;
        gaps_on          = 1'b1;
        stall_pct        = 25;
        hold_req         = 1'b0;

        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_directed_automaton();
        test_backpressure();
        test_random_words();
        test_long_epsilon_chain();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("nfa_epsilon_matcher_test OK");
        else
            $display("nfa_epsilon_matcher_test NOT OK");
        $finish;
    end

endmodule
